// ===== design/rccp_pkg.sv =====
// ----------------------------------------------------------------------------
// rccp_pkg: shared types, constants and helpers of the cylinder pick core
// Number formats, pipeline depths, candidate indexes and the saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rccp_pkg;

   // Fractional bits of the Q.16 fixed point format.
   localparam int FRAC_BITS = 16;

   // Depth of the coefficient and discriminant front end.
   localparam int FRONT_LAT = 4;

   // The square root produces one root bit per stage.
   localparam int SQRT_BITS = 32;
   localparam int RAD_W     = 2 * SQRT_BITS;

   // Quotient bits that are worked out; larger quotients saturate.
   localparam int QUO_BITS = 31;
   localparam int DIV_LAT  = QUO_BITS + 2;

   // Width of a division numerator before it is scaled by 2^FRAC_BITS.
   localparam int NQ_W = 34;

   // Stage that holds the division operands, and the depth up to the dividers' output.
   localparam int NUM_STAGE = FRONT_LAT + SQRT_BITS + 1;
   localparam int RAY_LAT   = NUM_STAGE + DIV_LAT;

   // Wide signed width used before saturation.
   localparam int WIDE_W = 66;

   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = -32'sh7FFF_FFFF - 32'sd1;
   localparam logic signed [63:0] Z_LIM = 64'sd4294967296;

   // Candidate order, which is also the order of the nearest-hit updates.
   localparam int NCAND          = 4;
   localparam int SIDE_CAND      = 2;
   localparam int CAND_SIDE_PLUS = 0;
   localparam int CAND_SIDE_MINUS = 1;
   localparam int CAND_TOP       = 2;
   localparam int CAND_BOTTOM    = 3;

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] sz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic signed [31:0] best;
      logic               side_ok;
   } ray_type;

   typedef struct packed {
      logic               side_ok;
      logic signed [31:0] b;
      logic signed [31:0] a;
   } quad_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] best;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } result_type;

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if (v > WIDE_W'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < WIDE_W'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== design/rccp_front.sv =====
// ----------------------------------------------------------------------------
// rccp_front: quadratic coefficients and discriminant
// Four stages: products, saturated A/b/C, b*b and A*C, then the discriminant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rccp_front import rccp_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] sx,
   input  logic signed [31:0] sy,
   input  logic signed [31:0] dx,
   input  logic signed [31:0] dy,
   output logic [RAD_W-1:0]   disc,
   output quad_type           quad
);

   logic signed [63:0] pxx_ff, pyy_ff, pxs_ff, pys_ff, sxx_ff, syy_ff;
   logic [63:0]        asum, csum;
   logic signed [64:0] bsum;
   logic signed [31:0] a_in, b_in, c_in, a_ff, b_ff, c_ff;
   logic signed [63:0] bb_ff, ac_ff;
   logic signed [31:0] a3_ff, b3_ff;
   logic signed [63:0] disc_in, disc_ff;
   quad_type           quad_in, quad_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pxx_ff <= dx * dx;
         pyy_ff <= dy * dy;
         pxs_ff <= dx * sx;
         pys_ff <= dy * sy;
         sxx_ff <= sx * sx;
         syy_ff <= sy * sy;
      end
   end

   // Both squares are non-negative, so their sum fits 64 unsigned bits.
   always_comb begin
      asum = $unsigned(pxx_ff) + $unsigned(pyy_ff);
      csum = $unsigned(sxx_ff) + $unsigned(syy_ff);
      bsum = 65'(pxs_ff) + 65'(pys_ff);
      a_in = (asum[63:47] != '0) ? Q_MAX : $signed({1'b0, asum[46:FRAC_BITS]});
      b_in = sat32(WIDE_W'(bsum >>> FRAC_BITS));
      c_in = sat32($signed({18'd0, csum[63:FRAC_BITS]}) - WIDE_W'(Q_ONE));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         c_ff  <= c_in;
         bb_ff <= b_ff * b_ff;
         ac_ff <= a_ff * c_ff;
         a3_ff <= a_ff;
         b3_ff <= b_ff;
      end
   end

   // The difference stays inside 64 signed bits for all saturated inputs.
   always_comb begin
      disc_in         = bb_ff - ac_ff;
      quad_in.side_ok = !disc_in[63] && (a3_ff != '0);
      quad_in.b       = b3_ff;
      quad_in.a       = a3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         disc_ff <= disc_in;
         quad_ff <= quad_in;
      end
   end

   assign disc = $unsigned(disc_ff);
   assign quad = quad_ff;

endmodule

// ===== design/rccp_isqrt.sv =====
// ----------------------------------------------------------------------------
// rccp_isqrt: pipelined integer square root
// Floor of the square root, one root bit per stage from the top bit down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rccp_isqrt import rccp_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [RAD_W-1:0]     value,
   output logic [SQRT_BITS-1:0] root
);

   logic [RAD_W-1:0]     rem_ff  [SQRT_BITS];
   logic [SQRT_BITS-1:0] root_ff [SQRT_BITS];

   for (genvar g = 0; g < SQRT_BITS; g++) begin : g_bit
      localparam int B = SQRT_BITS - 1 - g;
      logic [RAD_W-1:0]     rem_prev;
      logic [SQRT_BITS-1:0] root_prev;
      logic [RAD_W+1:0]     trial;

      if (g == 0) begin : g_first
         assign rem_prev  = value;
         assign root_prev = '0;
      end else begin : g_rest
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
      end

      // Growth of the square when this bit is set: 2*root*2^B + 2^(2B).
      assign trial = ((RAD_W+2)'(root_prev) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            if ((RAD_W+2)'(rem_prev) >= trial) begin
               rem_ff[g]  <= rem_prev - trial[RAD_W-1:0];
               root_ff[g] <= root_prev | (SQRT_BITS'(1) << B);
            end else begin
               rem_ff[g]  <= rem_prev;
               root_ff[g] <= root_prev;
            end
         end
      end
   end

   assign root = root_ff[SQRT_BITS-1];

endmodule

// ===== design/rccp_div.sv =====
// ----------------------------------------------------------------------------
// rccp_div: pipelined saturating fixed point divider
// Returns sat32(trunc(nq * 2^16 / den)) with one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rccp_div import rccp_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [NQ_W-1:0] nq,
   input  logic signed [31:0]     den,
   output logic signed [31:0]     quo
);

   localparam int HEAD_LO = QUO_BITS - FRAC_BITS;

   logic [NQ_W-1:0]     nmag;
   logic [31:0]         dmag;
   logic [31:0]         rem_ff [QUO_BITS];
   logic [31:0]         den_ff [QUO_BITS];
   logic [QUO_BITS-1:0] low_ff [QUO_BITS+1];
   logic                neg_ff [QUO_BITS+1];
   logic                ovf_ff [QUO_BITS+1];
   logic signed [31:0]  quo_in, quo_ff;
   logic signed [31:0]  qval;

   assign nmag = nq[NQ_W-1] ? $unsigned(-nq) : $unsigned(nq);
   assign dmag = den[31] ? $unsigned(-den) : $unsigned(den);

   // Quotients of 2^31 and above saturate, so only the low bits are iterated.
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= nq[NQ_W-1] ^ den[31];
         ovf_ff[0] <= 32'(nmag[NQ_W-1:HEAD_LO]) >= dmag;
         rem_ff[0] <= 32'(nmag[NQ_W-1:HEAD_LO]);
         den_ff[0] <= dmag;
         low_ff[0] <= {nmag[HEAD_LO-1:0], FRAC_BITS'(0)};
      end
   end

   for (genvar g = 1; g <= QUO_BITS; g++) begin : g_step
      logic [32:0] part;
      logic        ge;

      assign part = {rem_ff[g-1], low_ff[g-1][QUO_BITS-1]};
      assign ge   = part >= {1'b0, den_ff[g-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            low_ff[g] <= {low_ff[g-1][QUO_BITS-2:0], ge};
            neg_ff[g] <= neg_ff[g-1];
            ovf_ff[g] <= ovf_ff[g-1];
         end
      end

      if (g < QUO_BITS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g] <= ge ? 32'(part - {1'b0, den_ff[g-1]}) : part[31:0];
               den_ff[g] <= den_ff[g-1];
            end
         end
      end
   end

   always_comb begin
      qval = $signed({1'b0, low_ff[QUO_BITS]});
      if (ovf_ff[QUO_BITS]) begin
         quo_in = neg_ff[QUO_BITS] ? Q_MIN : Q_MAX;
      end else begin
         quo_in = neg_ff[QUO_BITS] ? -qval : qval;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// ===== design/rccp_back.sv =====
// ----------------------------------------------------------------------------
// rccp_back: hit points, range tests and nearest-hit selection
// Four stages: products, points and side z test, cap radius and side updates,
// cap updates into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rccp_back import rccp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               valid_in,
   input  ray_type            ray,
   input  logic signed [31:0] t_in [NCAND],
   output logic               res_valid,
   output result_type         res
);

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   ray_type            ray1_ff;
   logic signed [31:0] t1_ff [NCAND];
   logic signed [63:0] pxp_ff [NCAND];
   logic signed [63:0] pyp_ff [NCAND];
   logic signed [63:0] pzp_ff [SIDE_CAND];

   logic signed [63:0] zw [SIDE_CAND];
   logic signed [31:0] t2_ff [NCAND];
   logic signed [31:0] px2_ff [NCAND], py2_ff [NCAND], pz2_ff [NCAND];
   logic               ok2_in [NCAND], ok2_ff [NCAND];
   logic signed [31:0] px2_in [NCAND], py2_in [NCAND], pz2_in [NCAND];
   logic signed [31:0] best2_ff;

   logic [31:0]        ax [SIDE_CAND], ay [SIDE_CAND];
   logic [32:0]        r2 [SIDE_CAND];
   logic               cap_in [SIDE_CAND], cap_ff [SIDE_CAND];
   logic signed [31:0] ct3_ff [SIDE_CAND], cx3_ff [SIDE_CAND], cy3_ff [SIDE_CAND];
   logic signed [31:0] cz3_ff [SIDE_CAND];
   result_type         run3_in, run3_ff, res_in, res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray1_ff <= ray;
         for (int k = 0; k < NCAND; k++) begin
            t1_ff[k]  <= t_in[k];
            pxp_ff[k] <= t_in[k] * ray.dx;
            pyp_ff[k] <= t_in[k] * ray.dy;
         end
         for (int k = 0; k < SIDE_CAND; k++) begin
            pzp_ff[k] <= t_in[k] * ray.dz;
         end
      end
   end

   // Points: floor of (s*2^16 + t*d) / 2^16 is s plus the shifted product.
   always_comb begin
      for (int k = 0; k < NCAND; k++) begin
         px2_in[k] = sat32(WIDE_W'(ray1_ff.sx) + WIDE_W'(pxp_ff[k] >>> FRAC_BITS));
         py2_in[k] = sat32(WIDE_W'(ray1_ff.sy) + WIDE_W'(pyp_ff[k] >>> FRAC_BITS));
      end
      for (int k = 0; k < SIDE_CAND; k++) begin
         zw[k]     = (64'(ray1_ff.sz) <<< FRAC_BITS) + pzp_ff[k];
         pz2_in[k] = zw[k][FRAC_BITS+31:FRAC_BITS];
         ok2_in[k] = ray1_ff.side_ok && (zw[k] < Z_LIM) && (zw[k] > -Z_LIM);
      end
      pz2_in[CAND_TOP]    = Q_ONE;
      pz2_in[CAND_BOTTOM] = -Q_ONE;
      ok2_in[CAND_TOP]    = ray1_ff.dz != '0;
      ok2_in[CAND_BOTTOM] = ray1_ff.dz != '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         best2_ff <= ray1_ff.best;
         for (int k = 0; k < NCAND; k++) begin
            t2_ff[k]  <= t1_ff[k];
            px2_ff[k] <= px2_in[k];
            py2_ff[k] <= py2_in[k];
            pz2_ff[k] <= pz2_in[k];
            ok2_ff[k] <= ok2_in[k];
         end
      end
   end

   // Cap radius test, and the two side candidates folded into the running best.
   always_comb begin
      for (int k = 0; k < SIDE_CAND; k++) begin
         ax[k]     = px2_ff[SIDE_CAND+k][31] ? $unsigned(-px2_ff[SIDE_CAND+k])
                                             : $unsigned(px2_ff[SIDE_CAND+k]);
         ay[k]     = py2_ff[SIDE_CAND+k][31] ? $unsigned(-py2_ff[SIDE_CAND+k])
                                             : $unsigned(py2_ff[SIDE_CAND+k]);
         r2[k]     = 33'(32'(ax[k][FRAC_BITS-1:0]) * 32'(ax[k][FRAC_BITS-1:0]))
                   + 33'(32'(ay[k][FRAC_BITS-1:0]) * 32'(ay[k][FRAC_BITS-1:0]));
         cap_in[k] = ok2_ff[SIDE_CAND+k] && (ax[k][31:FRAC_BITS] == '0)
                   && (ay[k][31:FRAC_BITS] == '0) && !r2[k][32];
      end
      run3_in.hit  = 1'b0;
      run3_in.best = best2_ff;
      run3_in.px   = '0;
      run3_in.py   = '0;
      run3_in.pz   = '0;
      for (int k = 0; k < SIDE_CAND; k++) begin
         if (ok2_ff[k] && (run3_in.best > t2_ff[k])) begin
            run3_in.hit  = 1'b1;
            run3_in.best = t2_ff[k];
            run3_in.px   = px2_ff[k];
            run3_in.py   = py2_ff[k];
            run3_in.pz   = pz2_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         run3_ff <= run3_in;
         for (int k = 0; k < SIDE_CAND; k++) begin
            cap_ff[k] <= cap_in[k];
            ct3_ff[k] <= t2_ff[SIDE_CAND+k];
            cx3_ff[k] <= px2_ff[SIDE_CAND+k];
            cy3_ff[k] <= py2_ff[SIDE_CAND+k];
            cz3_ff[k] <= pz2_ff[SIDE_CAND+k];
         end
      end
   end

   always_comb begin
      res_in = run3_ff;
      for (int k = 0; k < SIDE_CAND; k++) begin
         if (cap_ff[k] && (res_in.best > ct3_ff[k])) begin
            res_in.hit  = 1'b1;
            res_in.best = ct3_ff[k];
            res_in.px   = cx3_ff[k];
            res_in.py   = cy3_ff[k];
            res_in.pz   = cz3_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = v4_ff;
   assign res       = res_ff;

endmodule

// ===== design/ray_capped_cylinder_pick_core.sv =====
// ----------------------------------------------------------------------------
// ray_capped_cylinder_pick_core: ray pick against a capped unit cylinder
// Streams rays through coefficient, square root, division and selection
// stages and reports the nearest hit against the supplied running best.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall start_x/y/z, dir_x/y/z, best_t
//   rsp_      out        rsp_valid/rsp_stall hit, new_best_t, pos_x/y/z
//
// One transaction enters per clock cycle while the pipeline advances; each result
// passes 4 front stages, 32 square root stages (one root bit each), one operand
// stage, 33 divider stages (31 quotient bits plus setup and saturation) and
// 4 selection stages whose last register is the output register.
// All stages share one advance enable. While a result waits under rsp_stall
// the whole pipeline holds and req_stall is raised; otherwise it advances.
// Synchronous reset clears only the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_capped_cylinder_pick_core import rccp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic signed [31:0] req_best_t,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_new_best_t,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z
);

   logic                   en;
   ray_type                ray_in, ray_fix;
   ray_type                ray_ff [RAY_LAT];
   logic [RAY_LAT-1:0]     valid_ff;
   logic [RAD_W-1:0]       disc;
   quad_type               quad;
   quad_type               side_ff [SQRT_BITS];
   logic [SQRT_BITS-1:0]   root;
   logic signed [NQ_W-1:0] root_x, b_x;
   logic signed [NQ_W-1:0] nq_in [NCAND], nq_ff [NCAND];
   logic signed [31:0]     den_in [NCAND], den_ff [NCAND];
   logic signed [31:0]     t_div [NCAND];
   logic                   res_valid;
   result_type             res;

   // The pipeline moves unless a finished result is held at the output.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      ray_in.sx      = req_start_x;
      ray_in.sy      = req_start_y;
      ray_in.sz      = req_start_z;
      ray_in.dx      = req_dir_x;
      ray_in.dy      = req_dir_y;
      ray_in.dz      = req_dir_z;
      ray_in.best    = req_best_t;
      ray_in.side_ok = 1'b0;
   end

   // The side test flag joins the ray record once the root is known.
   always_comb begin
      ray_fix         = ray_ff[NUM_STAGE-2];
      ray_fix.side_ok = side_ff[SQRT_BITS-1].side_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[RAY_LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray_ff[0] <= ray_in;
         for (int i = 1; i < RAY_LAT; i++) begin
            if (i == NUM_STAGE - 1) begin
               ray_ff[i] <= ray_fix;
            end else begin
               ray_ff[i] <= ray_ff[i-1];
            end
         end
         side_ff[0] <= quad;
         for (int i = 1; i < SQRT_BITS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   rccp_front u_front (
      .clock (clock),
      .en    (en),
      .sx    (req_start_x),
      .sy    (req_start_y),
      .dx    (req_dir_x),
      .dy    (req_dir_y),
      .disc  (disc),
      .quad  (quad)
   );

   rccp_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .value (disc),
      .root  (root)
   );

   // Division operands: the two side roots -b +/- s over A, and the two cap
   // planes (+/-1 - sz) over dz. The scaling by 2^16 happens in the divider.
   always_comb begin
      root_x = NQ_W'(root);
      b_x    = NQ_W'(side_ff[SQRT_BITS-1].b);
      nq_in[CAND_SIDE_PLUS]   = root_x - b_x;
      nq_in[CAND_SIDE_MINUS]  = -b_x - root_x;
      nq_in[CAND_TOP]         = NQ_W'(Q_ONE) - NQ_W'(ray_ff[NUM_STAGE-2].sz);
      nq_in[CAND_BOTTOM]      = -NQ_W'(Q_ONE) - NQ_W'(ray_ff[NUM_STAGE-2].sz);
      den_in[CAND_SIDE_PLUS]  = side_ff[SQRT_BITS-1].a;
      den_in[CAND_SIDE_MINUS] = side_ff[SQRT_BITS-1].a;
      den_in[CAND_TOP]        = ray_ff[NUM_STAGE-2].dz;
      den_in[CAND_BOTTOM]     = ray_ff[NUM_STAGE-2].dz;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NCAND; k++) begin
            nq_ff[k]  <= nq_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   end

   for (genvar k = 0; k < NCAND; k++) begin : g_div
      rccp_div u_div (
         .clock (clock),
         .en    (en),
         .nq    (nq_ff[k]),
         .den   (den_ff[k]),
         .quo   (t_div[k])
      );
   end

   rccp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (valid_ff[RAY_LAT-1]),
      .ray       (ray_ff[RAY_LAT-1]),
      .t_in      (t_div),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid      = res_valid;
   assign rsp_hit        = res.hit;
   assign rsp_new_best_t = res.best;
   assign rsp_pos_x      = res.px;
   assign rsp_pos_y      = res.py;
   assign rsp_pos_z      = res.pz;

   // No result is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A held output freezes every in-flight valid bit.
   a_hold_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved while the output was held");

   // Without a hit the reported point is the origin.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0)
      else $error("miss reported with a nonzero point");

   // Every accepted hit lies between the two cap planes.
   a_hit_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_pos_z >= -Q_ONE && rsp_pos_z <= Q_ONE)
      else $error("hit point outside the cap planes");

endmodule
